/* sv/trz_pkg.sv */
// Shared types, constants and helpers of the triangle rasterizer.
package trz_pkg;

   localparam int FRAME_W    = 128;
   localparam int FRAME_H    = 128;
   localparam int CRD_W      = 13;
   localparam int VAL_W      = 17;
   localparam int FRAC_BITS  = 16;
   localparam int FRAC_W     = FRAC_BITS + 1;
   localparam int DIV_W      = 12;
   localparam int NUM_F      = 5;

   localparam logic [23:0]       CLEAR_COLOR_RST = 24'h335580;
   localparam logic [15:0]       DEPTH_MAX       = 16'hFFFF;
   localparam logic [FRAC_W-1:0] FRAC_ONE        = FRAC_W'(1) << FRAC_BITS;

   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_VERTEX = 2'd1;
   localparam logic [1:0] MODE_READ   = 2'd2;
   localparam logic [1:0] VIDX_DRAW   = 2'd2;

   localparam logic [2:0] F_X = 3'd0;
   localparam logic [2:0] F_Z = 3'd1;
   localparam logic [2:0] F_R = 3'd2;
   localparam logic [2:0] F_G = 3'd3;
   localparam logic [2:0] F_B = 3'd4;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0]        z;
      logic [23:0]        color;
   } vtx_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [FRAC_W-1:0] quot;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_RD_WAIT, ST_SORT0, ST_SORT1, ST_SORT2, ST_SETUP,
      ST_ROW_CHK, ST_ROW_DIVA, ST_ROW_DIVB, ST_ROW_LERP, ST_SPAN,
      ST_PIX_CHK, ST_PIX_DIV, ST_PIX_LERP, ST_PIX_RD
   } state_type;

   // 1/16 units to whole units, truncated toward zero
   function automatic logic signed [CRD_W-1:0] trunc16(input logic signed [VAL_W-1:0] v);
      logic signed [VAL_W:0] s;
      s = (VAL_W+1)'(v) + (v[VAL_W-1] ? (VAL_W+1)'(15) : (VAL_W+1)'(0));
      return CRD_W'(s >>> 4);
   endfunction

   function automatic logic signed [VAL_W-1:0] vtx_field(input vtx_type v,
                                                         input logic [2:0] k);
      logic signed [VAL_W-1:0] r;
      r = '0;
      case (k)
         F_X: r = VAL_W'(v.x);
         F_Z: r = VAL_W'(v.z);
         F_R: r = VAL_W'(v.color[23:16]);
         F_G: r = VAL_W'(v.color[15:8]);
         F_B: r = VAL_W'(v.color[7:0]);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* sv/trz_ram.sv */
// Generic single-port RAM with registered read.
module trz_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [DATA_W-1:0]        wdata,
   output logic [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/trz_div.sv */
// Restoring divider for interpolation fractions, one quotient bit per cycle.
module trz_div (
   input  logic                 clock,
   input  logic                 reset,
   input  trz_pkg::div_req_type req,
   output trz_pkg::div_rsp_type rsp
);
   import trz_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  den_ff, den_in;
   logic [FRAC_W-1:0] quot_ff, quot_in;
   logic [DIV_W:0]    rem2;
   logic              fits;

   assign rem2 = {rem_ff, 1'b0};
   assign fits = rem2 >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (busy_ff) begin
         rem_in  = fits ? DIV_W'(rem2 - {1'b0, den_ff}) : DIV_W'(rem2);
         quot_in = {quot_ff[FRAC_W-2:0], fits};
         cnt_in  = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         den_in = req.den;
         if (req.den == '0) begin
            quot_in = '0;
            done_in = 1'b1;
         end else if (req.num >= req.den) begin
            quot_in = FRAC_ONE;
            done_in = 1'b1;
         end else begin
            rem_in  = req.num;
            quot_in = '0;
            cnt_in  = 5'(FRAC_BITS);
            busy_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

/* sv/trz_lerp.sv */
// Interpolator a + floor((b - a) * t / 65536), product registered.
module trz_lerp (
   input  logic                                 clock,
   input  logic signed [trz_pkg::VAL_W-1:0]     a,
   input  logic signed [trz_pkg::VAL_W-1:0]     b,
   input  logic        [trz_pkg::FRAC_W-1:0]    t,
   output logic signed [trz_pkg::VAL_W-1:0]     res
);
   import trz_pkg::*;

   localparam int PROD_W = VAL_W + FRAC_W + 2;

   logic signed [VAL_W:0]    diff;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic signed [VAL_W-1:0]  a_ff;

   assign diff    = (VAL_W+1)'(b) - (VAL_W+1)'(a);
   assign prod_in = diff * $signed({1'b0, t});

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      a_ff    <= a;
   end

   assign res = a_ff + prod_ff[FRAC_BITS+VAL_W-1:FRAC_BITS];

endmodule

/* sv/triangle_rasterizer_zbuffer_unit.sv */
// Scanline triangle rasterizer with Gouraud shading and depth-tested stores.
//
//  channel   ports                            handshake
//  request   req_*                            start high while busy low
//  response  rsp_pixel_color, rsp_pixel_depth rsp_valid, one cycle, no stall
//  config    csr_wdata (clear_color)          csr_we
//
// Vertex words 0 and 1 are latched without leaving idle; a read answers from ST_RD_WAIT
// through the response registers. A clear sweeps the stores one pixel a cycle, all WIDTH*HEIGHT addresses.
// A draw sorts and sets up the vertices, then per row runs two divides and ten
// lerps, and per pixel a divide, the lerps and the depth read-modify-write, with
// the 16-step divider.
// Reset clears control and vertex latches; store contents are undefined until cleared.
module triangle_rasterizer_zbuffer_unit #(
   parameter int WIDTH  = trz_pkg::FRAME_W,
   parameter int HEIGHT = trz_pkg::FRAME_H
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic [1:0]         req_vertex_index,
   input  logic signed [15:0] req_x_pos,
   input  logic signed [15:0] req_y_pos,
   input  logic [15:0]        req_depth_in,
   input  logic [23:0]        req_color_in,
   input  logic [6:0]         req_pixel_x,
   input  logic [6:0]         req_pixel_y,
   output logic               rsp_valid,
   output logic [23:0]        rsp_pixel_color,
   output logic [15:0]        rsp_pixel_depth,
   input  logic               csr_we,
   input  logic [23:0]        csr_wdata
);
   import trz_pkg::*;

   localparam int NPIX   = WIDTH * HEIGHT;
   localparam int ADDR_W = $clog2(NPIX);
   localparam logic signed [CRD_W-1:0] XMAX = CRD_W'(WIDTH - 1);
   localparam logic signed [CRD_W-1:0] YMAX = CRD_W'(HEIGHT - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(NPIX - 1);
   localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(WIDTH);
   localparam logic [3:0] ROW_OPS = 4'(2 * NUM_F);
   localparam logic [3:0] PIX_OPS = 4'(NUM_F - 1);

   state_type               state_ff, state_in;
   logic [23:0]             clear_color_ff, clear_color_in;
   vtx_type                 vlat_ff [2];
   vtx_type                 vlat_in [2];
   vtx_type                 vtx_ff [3];
   vtx_type                 vtx_in [3];
   logic signed [CRD_W-1:0] iy0_ff, iy0_in, iy1_ff, iy1_in, iy2_ff, iy2_in;
   logic signed [CRD_W-1:0] y_ff, y_in, ye_ff, ye_in;
   logic signed [CRD_W-1:0] x_ff, x_in, xe_ff, xe_in;
   logic signed [CRD_W-1:0] ixa_ff, ixa_in, ixb_ff, ixb_in;
   logic [ADDR_W-1:0]       row_base_ff, row_base_in;
   logic [ADDR_W-1:0]       clr_cnt_ff, clr_cnt_in;
   logic [FRAC_W-1:0]       ta_ff, ta_in, tb_ff, tb_in, tx_ff, tx_in;
   logic [3:0]              lcnt_ff, lcnt_in;
   logic signed [VAL_W-1:0] res_ff [2*NUM_F];
   logic signed [VAL_W-1:0] res_in [2*NUM_F];
   logic signed [VAL_W-1:0] pa_ff [NUM_F];
   logic signed [VAL_W-1:0] pa_in [NUM_F];
   logic signed [VAL_W-1:0] pb_ff [NUM_F];
   logic signed [VAL_W-1:0] pb_in [NUM_F];
   logic                    oob_ff, oob_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [23:0]             rsp_color_ff, rsp_color_in;
   logic [15:0]             rsp_depth_ff, rsp_depth_in;

   div_req_type             div_req;
   div_rsp_type             div_rsp;
   logic signed [VAL_W-1:0] lerp_a, lerp_b, lerp_res;
   logic [FRAC_W-1:0]       lerp_t;
   logic [2:0]              fk, pidx;

   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_addr, pix_addr;
   logic [23:0]             color_wdata, color_rdata;
   logic [15:0]             depth_wdata, depth_rdata;

   logic signed [CRD_W-1:0] iy0_c, iy1_c, iy2_c, ixa_c, ixb_c;
   logic                    span_swap;
   vtx_type                 vin, t0, t1;

   assign vin      = '{x: req_x_pos, y: req_y_pos, z: req_depth_in, color: req_color_in};
   assign iy0_c    = trunc16(VAL_W'(vtx_ff[0].y));
   assign iy1_c    = trunc16(VAL_W'(vtx_ff[1].y));
   assign iy2_c    = trunc16(VAL_W'(vtx_ff[2].y));
   assign span_swap = res_ff[F_X] > res_ff[NUM_F];
   assign ixa_c    = trunc16(span_swap ? res_ff[NUM_F] : res_ff[F_X]);
   assign ixb_c    = trunc16(span_swap ? res_ff[F_X] : res_ff[NUM_F]);
   assign pix_addr = row_base_ff + ADDR_W'($unsigned(x_ff));

   // interpolator operand select
   always_comb begin
      fk   = 3'(lcnt_ff - 4'(NUM_F));
      pidx = (lcnt_ff < PIX_OPS) ? 3'(lcnt_ff + 4'd1) : F_B;
      t0   = vtx_ff[1];
      t1   = vtx_ff[2];
      if (state_ff == ST_ROW_LERP) begin
         if (lcnt_ff < 4'(NUM_F)) begin
            lerp_a = vtx_field(vtx_ff[0], 3'(lcnt_ff));
            lerp_b = vtx_field(vtx_ff[2], 3'(lcnt_ff));
            lerp_t = ta_ff;
         end else begin
            if (y_ff < iy1_ff) begin
               t0 = vtx_ff[0];
               t1 = vtx_ff[1];
            end
            lerp_a = vtx_field(t0, fk);
            lerp_b = vtx_field(t1, fk);
            lerp_t = tb_ff;
         end
      end else begin
         lerp_a = pa_ff[pidx];
         lerp_b = pb_ff[pidx];
         lerp_t = tx_ff;
      end
   end

   always_comb begin
      state_in       = state_ff;
      clear_color_in = csr_we ? csr_wdata : clear_color_ff;
      vlat_in        = vlat_ff;
      vtx_in         = vtx_ff;
      iy0_in         = iy0_ff;
      iy1_in         = iy1_ff;
      iy2_in         = iy2_ff;
      y_in           = y_ff;
      ye_in          = ye_ff;
      x_in           = x_ff;
      xe_in          = xe_ff;
      ixa_in         = ixa_ff;
      ixb_in         = ixb_ff;
      row_base_in    = row_base_ff;
      clr_cnt_in     = clr_cnt_ff;
      ta_in          = ta_ff;
      tb_in          = tb_ff;
      tx_in          = tx_ff;
      lcnt_in        = lcnt_ff;
      res_in         = res_ff;
      pa_in          = pa_ff;
      pb_in          = pb_ff;
      oob_in         = oob_ff;
      rsp_valid_in   = 1'b0;
      rsp_color_in   = rsp_color_ff;
      rsp_depth_in   = rsp_depth_ff;
      div_req        = '0;
      ram_we         = 1'b0;
      ram_addr       = pix_addr;
      color_wdata    = {res_ff[1][7:0], res_ff[2][7:0], res_ff[3][7:0]};
      depth_wdata    = res_ff[0][15:0];

      unique case (state_ff)
         ST_IDLE: begin
            ram_addr = ADDR_W'(req_pixel_y) * ROW_STRIDE + ADDR_W'(req_pixel_x);
            if (start) begin
               case (req_mode)
                  MODE_CLEAR: begin
                     clr_cnt_in = '0;
                     state_in   = ST_CLEAR;
                  end
                  MODE_VERTEX: begin
                     if (req_vertex_index == VIDX_DRAW) begin
                        vtx_in[0] = vlat_ff[0];
                        vtx_in[1] = vlat_ff[1];
                        vtx_in[2] = vin;
                        state_in  = ST_SORT0;
                     end else if (!req_vertex_index[1]) begin
                        vlat_in[req_vertex_index[0]] = vin;
                     end
                  end
                  MODE_READ: begin
                     oob_in   = (13'(req_pixel_x) >= 13'(WIDTH)) ||
                                (13'(req_pixel_y) >= 13'(HEIGHT));
                     state_in = ST_RD_WAIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            ram_addr    = clr_cnt_ff;
            ram_we      = 1'b1;
            color_wdata = clear_color_ff;
            depth_wdata = DEPTH_MAX;
            clr_cnt_in  = clr_cnt_ff + ADDR_W'(1);
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_RD_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_color_in = oob_ff ? '0 : color_rdata;
            rsp_depth_in = oob_ff ? '0 : depth_rdata;
            state_in     = ST_IDLE;
         end
         ST_SORT0, ST_SORT2: begin
            if (vtx_ff[0].y > vtx_ff[1].y) begin
               vtx_in[0] = vtx_ff[1];
               vtx_in[1] = vtx_ff[0];
            end
            state_in = (state_ff == ST_SORT0) ? ST_SORT1 : ST_SETUP;
         end
         ST_SORT1: begin
            if (vtx_ff[1].y > vtx_ff[2].y) begin
               vtx_in[1] = vtx_ff[2];
               vtx_in[2] = vtx_ff[1];
            end
            state_in = ST_SORT2;
         end
         ST_SETUP: begin
            iy0_in   = iy0_c;
            iy1_in   = iy1_c;
            iy2_in   = iy2_c;
            y_in     = iy0_c[CRD_W-1] ? '0 : iy0_c;
            ye_in    = (iy2_c > YMAX) ? YMAX : iy2_c;
            state_in = (iy0_c == iy2_c) ? ST_IDLE : ST_ROW_CHK;
         end
         ST_ROW_CHK: begin
            if (y_ff > ye_ff) begin
               state_in = ST_IDLE;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = DIV_W'(y_ff - iy0_ff);
               div_req.den   = DIV_W'(iy2_ff - iy0_ff);
               row_base_in   = ADDR_W'($unsigned(y_ff)) * ROW_STRIDE;
               state_in      = ST_ROW_DIVA;
            end
         end
         ST_ROW_DIVA: begin
            if (div_rsp.done) begin
               ta_in         = div_rsp.quot;
               div_req.start = 1'b1;
               if (y_ff < iy1_ff) begin
                  div_req.num = DIV_W'(y_ff - iy0_ff);
                  div_req.den = DIV_W'(iy1_ff - iy0_ff);
               end else begin
                  div_req.num = DIV_W'(y_ff - iy1_ff);
                  div_req.den = DIV_W'(iy2_ff - iy1_ff);
               end
               state_in = ST_ROW_DIVB;
            end
         end
         ST_ROW_DIVB: begin
            if (div_rsp.done) begin
               tb_in    = div_rsp.quot;
               lcnt_in  = '0;
               state_in = ST_ROW_LERP;
            end
         end
         ST_ROW_LERP, ST_PIX_LERP: begin
            lcnt_in = lcnt_ff + 4'd1;
            if (lcnt_ff != 4'd0) begin
               res_in[lcnt_ff - 4'd1] = lerp_res;
            end
            if (state_ff == ST_ROW_LERP && lcnt_ff == ROW_OPS) begin
               state_in = ST_SPAN;
            end else if (state_ff == ST_PIX_LERP && lcnt_ff == PIX_OPS) begin
               state_in = ST_PIX_RD;
            end
         end
         ST_SPAN: begin
            for (int i = 0; i < NUM_F; i++) begin
               pa_in[i] = span_swap ? res_ff[i + NUM_F] : res_ff[i];
               pb_in[i] = span_swap ? res_ff[i] : res_ff[i + NUM_F];
            end
            ixa_in   = ixa_c;
            ixb_in   = ixb_c;
            x_in     = ixa_c[CRD_W-1] ? '0 : ixa_c;
            xe_in    = (ixb_c > XMAX) ? XMAX : ixb_c;
            state_in = ST_PIX_CHK;
         end
         ST_PIX_CHK: begin
            if (x_ff > xe_ff) begin
               y_in     = y_ff + CRD_W'(1);
               state_in = ST_ROW_CHK;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = DIV_W'(x_ff - ixa_ff);
               div_req.den   = DIV_W'(ixb_ff - ixa_ff);
               state_in      = ST_PIX_DIV;
            end
         end
         ST_PIX_DIV: begin
            if (div_rsp.done) begin
               tx_in    = div_rsp.quot;
               lcnt_in  = '0;
               state_in = ST_PIX_LERP;
            end
         end
         ST_PIX_RD: begin
            // depth read while pix_wr_ff is low, then tested and written once pix_wr_ff is set
            state_in = ST_PIX_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // write phase of the pixel read-modify-write: depth test and store
   logic pix_wr_ff;
   logic pix_wr_in;
   logic pix_hit;

   assign pix_wr_in = (state_ff == ST_PIX_RD) && !pix_wr_ff;
   assign pix_hit   = pix_wr_ff && (res_ff[0][15:0] < depth_rdata);

   state_type state_nx;
   logic signed [CRD_W-1:0] x_nx;
   always_comb begin
      state_nx = state_in;
      x_nx     = x_in;
      if (state_ff == ST_PIX_RD) begin
         state_nx = pix_wr_ff ? ST_PIX_CHK : ST_PIX_RD;
         if (pix_wr_ff) begin
            x_nx = x_ff + CRD_W'(1);
         end
      end
   end

   trz_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   trz_lerp u_lerp (
      .clock (clock),
      .a     (lerp_a),
      .b     (lerp_b),
      .t     (lerp_t),
      .res   (lerp_res)
   );

   trz_ram #(.DATA_W(24), .DEPTH(NPIX)) u_color_ram (
      .clock (clock),
      .we    (ram_we || pix_hit),
      .addr  (ram_addr),
      .wdata (color_wdata),
      .rdata (color_rdata)
   );

   trz_ram #(.DATA_W(16), .DEPTH(NPIX)) u_depth_ram (
      .clock (clock),
      .we    (ram_we || pix_hit),
      .addr  (ram_addr),
      .wdata (depth_wdata),
      .rdata (depth_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         clear_color_ff <= CLEAR_COLOR_RST;
         vlat_ff[0]     <= '0;
         vlat_ff[1]     <= '0;
         rsp_valid_ff   <= 1'b0;
         pix_wr_ff      <= 1'b0;
      end else begin
         state_ff       <= state_nx;
         clear_color_ff <= clear_color_in;
         vlat_ff        <= vlat_in;
         rsp_valid_ff   <= rsp_valid_in;
         pix_wr_ff      <= pix_wr_in;
      end
      vtx_ff       <= vtx_in;
      iy0_ff       <= iy0_in;
      iy1_ff       <= iy1_in;
      iy2_ff       <= iy2_in;
      y_ff         <= y_in;
      ye_ff        <= ye_in;
      x_ff         <= x_nx;
      xe_ff        <= xe_in;
      ixa_ff       <= ixa_in;
      ixb_ff       <= ixb_in;
      row_base_ff  <= row_base_in;
      clr_cnt_ff   <= clr_cnt_in;
      ta_ff        <= ta_in;
      tb_ff        <= tb_in;
      tx_ff        <= tx_in;
      lcnt_ff      <= lcnt_in;
      res_ff       <= res_in;
      pa_ff        <= pa_in;
      pb_ff        <= pb_in;
      oob_ff       <= oob_in;
      rsp_color_ff <= rsp_color_in;
      rsp_depth_ff <= rsp_depth_in;
   end

   assign busy            = state_ff != ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_pixel_depth = rsp_depth_ff;

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_RD_WAIT))
      else $error("response without a pending read");

   a_pix_in_frame: assert property (@(posedge clock) disable iff (reset)
      pix_hit |-> (x_ff >= 0 && x_ff <= XMAX && y_ff >= 0 && y_ff <= YMAX))
      else $error("pixel write outside the frame");

   a_div_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_ROW_DIVA || state_ff == ST_ROW_DIVB ||
                        state_ff == ST_PIX_DIV))
      else $error("divider result with no consumer");

   a_pix_wr_pair: assert property (@(posedge clock) disable iff (reset)
      pix_wr_ff |-> $past(state_ff == ST_PIX_RD) && state_ff == ST_PIX_RD)
      else $error("depth test out of sequence");

endmodule
